[rtl/rotary_encoder_wrap_counter_defines.svh]
// assertion macros shared by the rtl
`ifndef ROTARY_ENCODER_WRAP_COUNTER_DEFINES_SVH
`define ROTARY_ENCODER_WRAP_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// condition that must hold in the same cycle as its trigger
`define REWC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rewc check failed");

// condition that must hold in the cycle after its trigger
`define REWC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rewc check failed");

`else

`define REWC_ASSERT_SAME(label, clk, rst, ante, cons)
`define REWC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/rewc_pkg.sv]
package rewc_pkg;

   // operation codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // tick state machine phases
   localparam logic [2:0] PHASE_WAIT_HIGH = 3'd0;
   localparam logic [2:0] PHASE_SETTLE    = 3'd1;
   localparam logic [2:0] PHASE_DISPLAY   = 3'd2;
   localparam logic [2:0] PHASE_REARM     = 3'd3;
   localparam logic [2:0] PHASE_IDLE      = 3'd4;

   // register indexes
   localparam logic [1:0] REG_MAX_POSITION = 2'd0;
   localparam logic [1:0] REG_MIN_POSITION = 2'd1;
   localparam logic [1:0] REG_SETTLE_TICKS = 2'd2;

   // reset values of the registers
   localparam logic [7:0] RESET_MAX_POSITION = 8'd255;
   localparam logic [7:0] RESET_MIN_POSITION = 8'd0;
   localparam logic [7:0] RESET_SETTLE_TICKS = 8'd10;

   typedef struct packed {
      logic [7:0] max_position;
      logic [7:0] min_position;
      logic [7:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic       operation;
      logic       edge_a;
      logic       edge_b;
      logic       level_a;
      logic       level_b;
      logic [7:0] new_position;
   } item_type;

   typedef struct packed {
      logic [7:0] position;
      logic       display_update;
      logic       led_level;
      logic       armed;
   } result_type;

endpackage

[rtl/rewc_csr.sv]
module rewc_csr
   import rewc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   // register writes, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_MAX_POSITION: cfg_in.max_position = pwdata[7:0];
            REG_MIN_POSITION: cfg_in.min_position = pwdata[7:0];
            REG_SETTLE_TICKS: cfg_in.settle_ticks = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_position <= RESET_MAX_POSITION;
         cfg_ff.min_position <= RESET_MIN_POSITION;
         cfg_ff.settle_ticks <= RESET_SETTLE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_index)
         REG_MAX_POSITION: prdata = {24'd0, cfg_ff.max_position};
         REG_MIN_POSITION: prdata = {24'd0, cfg_ff.min_position};
         REG_SETTLE_TICKS: prdata = {24'd0, cfg_ff.settle_ticks};
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/rewc_tracker.sv]
`include "rotary_encoder_wrap_counter_defines.svh"

module rewc_tracker
   import rewc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] settle_count_ff, settle_count_in;
   logic       direction_up_ff, direction_up_in;
   logic       edge_enable_ff, edge_enable_in;
   logic [7:0] position_ff, position_in;
   logic       led_ff, led_in;
   logic       display_in;
   logic [7:0] settle_dec;
   logic [7:0] stepped;

   // settle counter runs down once per tick
   assign settle_dec = (settle_count_ff != 8'd0) ? settle_count_ff - 8'd1 : 8'd0;

   // wrapping step in the latched direction
   always_comb begin
      if (direction_up_in) begin
         stepped = (position_ff < cfg.max_position) ? position_ff + 8'd1
                                                    : cfg.min_position;
      end else begin
         stepped = (position_ff > cfg.min_position) ? position_ff - 8'd1
                                                    : cfg.max_position;
      end
   end

   // next state for one item
   always_comb begin
      phase_in        = phase_ff;
      settle_count_in = settle_count_ff;
      direction_up_in = direction_up_ff;
      edge_enable_in  = edge_enable_ff;
      position_in     = position_ff;
      led_in          = led_ff;
      display_in      = 1'b0;
      if (item.operation == OP_LOAD) begin
         position_in = item.new_position;
      end else begin
         // first edge while armed fixes the direction, A wins
         if (edge_enable_ff && (item.edge_a || item.edge_b)) begin
            direction_up_in = !item.edge_a;
            edge_enable_in  = 1'b0;
            led_in          = !led_ff;
         end
         settle_count_in = settle_dec;
         case (phase_ff)
            PHASE_WAIT_HIGH: begin
               if (item.level_a && item.level_b) begin
                  phase_in        = PHASE_SETTLE;
                  settle_count_in = cfg.settle_ticks;
               end
            end
            PHASE_SETTLE: begin
               if (settle_dec == 8'd0) begin
                  position_in = stepped;
                  phase_in    = PHASE_DISPLAY;
               end
            end
            PHASE_DISPLAY: begin
               display_in = 1'b1;
               phase_in   = PHASE_REARM;
            end
            PHASE_REARM: begin
               edge_enable_in = 1'b1;
               phase_in       = PHASE_IDLE;
            end
            PHASE_IDLE: begin
               if (!edge_enable_in) begin
                  phase_in = PHASE_WAIT_HIGH;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
            end
         endcase
      end
   end

   // state registers, updated per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_IDLE;
         settle_count_ff <= 8'd0;
         direction_up_ff <= 1'b0;
         edge_enable_ff  <= 1'b1;
         position_ff     <= 8'd0;
         led_ff          <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         settle_count_ff <= settle_count_in;
         direction_up_ff <= direction_up_in;
         edge_enable_ff  <= edge_enable_in;
         position_ff     <= position_in;
         led_ff          <= led_in;
      end
   end

   assign result.position       = position_in;
   assign result.display_update = display_in;
   assign result.led_level      = led_in;
   assign result.armed          = edge_enable_in;

   // checks
   `REWC_ASSERT_NEXT(display_then_rearm, clock, reset,
      accept && item.operation == OP_TICK && phase_ff == PHASE_DISPLAY,
      phase_ff == PHASE_REARM && !edge_enable_ff)
   `REWC_ASSERT_SAME(disarm_toggles_led, clock, reset,
      $fell(edge_enable_ff), led_ff != $past(led_ff))
   `REWC_ASSERT_SAME(settle_only_in_settle, clock, reset,
      settle_count_ff != 8'd0, phase_ff == PHASE_SETTLE)
   `REWC_ASSERT_NEXT(state_holds_when_idle, clock, reset,
      !accept, $stable(position_ff) && $stable(phase_ff) && $stable(led_ff))

endmodule

[rtl/rotary_encoder_wrap_counter.sv]
// Rotary encoder decoder with a wrapping position counter. Each item is either a
// tick carrying falling-edge flags and levels of channels A and B, or a load of
// the position. Items are taken one per clock cycle while the result side keeps
// up; req_ready is high whenever the result register is empty or its item is
// being taken in the same cycle, so a steady stream with rsp_ready high runs at
// one item per cycle. The result of an item appears on the rsp_ channel in the
// cycle after acceptance, held in the single result register after the tick
// state machine. The settle wait is counted in ticks, not clock cycles.
// Registers: max_position at 0x0, min_position at 0x4, settle_ticks at 0x8;
// write them only while the block is idle.
module rotary_encoder_wrap_counter
   import rewc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic        req_edge_a,
   input  logic        req_edge_b,
   input  logic        req_level_a,
   input  logic        req_level_b,
   input  logic [7:0]  req_new_position,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_position,
   output logic        rsp_display_update,
   output logic        rsp_led_level,
   output logic        rsp_armed,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg;
   item_type   item;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // register block
   rewc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake: accept whenever the result slot frees up
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign item.operation    = req_operation;
   assign item.edge_a       = req_edge_a;
   assign item.edge_b       = req_edge_b;
   assign item.level_a      = req_level_a;
   assign item.level_b      = req_level_b;
   assign item.new_position = req_new_position;

   // tick state machine
   rewc_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   // result register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_data_ff.position;
   assign rsp_display_update = rsp_data_ff.display_update;
   assign rsp_led_level      = rsp_data_ff.led_level;
   assign rsp_armed          = rsp_data_ff.armed;

endmodule

[sim/rewc_checker.sv]
`timescale 1ns / 1ps

// watches both item channels and the register port, predicts each result item
// and compares it field by field with what the block delivers
module rewc_checker
   import rewc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_operation,
   input  logic        req_edge_a,
   input  logic        req_edge_b,
   input  logic        req_level_a,
   input  logic        req_level_b,
   input  logic [7:0]  req_new_position,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_position,
   input  logic        rsp_display_update,
   input  logic        rsp_led_level,
   input  logic        rsp_armed,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int          mismatches,
   output int          outstanding
);

   // shadow of the registers and of the decoder state
   cfg_type    cfg;
   logic [2:0] phase;
   logic [7:0] settle_left;
   logic       dir_up;
   logic       edges_armed;
   logic       led;
   logic [7:0] pos;

   // position reports still owed by the block, oldest first
   result_type position_reports[$];

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // one item through the decoder: edge capture first, then the tick machine
   task automatic decode_item(input item_type it, output result_type r);
      r.display_update = 1'b0;
      if (it.operation == OP_LOAD) begin
         pos = it.new_position;
      end else begin
         // first edge while armed fixes the direction, channel a wins
         if (edges_armed && (it.edge_a || it.edge_b)) begin
            dir_up      = !it.edge_a;
            edges_armed = 1'b0;
            led         = !led;
         end
         if (settle_left != 8'd0) settle_left = settle_left - 8'd1;
         case (phase)
            PHASE_WAIT_HIGH: begin
               if (it.level_a && it.level_b) begin
                  phase       = PHASE_SETTLE;
                  settle_left = cfg.settle_ticks;
               end
            end
            PHASE_SETTLE: begin
               if (settle_left == 8'd0) begin
                  // step with wrap between the range ends
                  if (dir_up)
                     pos = (pos < cfg.max_position) ? pos + 8'd1 : cfg.min_position;
                  else
                     pos = (pos > cfg.min_position) ? pos - 8'd1 : cfg.max_position;
                  phase = PHASE_DISPLAY;
               end
            end
            PHASE_DISPLAY: begin
               r.display_update = 1'b1;
               phase            = PHASE_REARM;
            end
            PHASE_REARM: begin
               edges_armed = 1'b1;
               phase       = PHASE_IDLE;
            end
            PHASE_IDLE: begin
               if (!edges_armed) phase = PHASE_WAIT_HIGH;
            end
            default: phase = PHASE_IDLE;
         endcase
      end
      r.position  = pos;
      r.led_level = led;
      r.armed     = edges_armed;
   endtask

   always @(posedge clock) begin : track
      item_type   it;
      result_type want;
      logic [7:0] reg_value;
      bit         reg_known;
      if (reset) begin
         cfg.max_position = RESET_MAX_POSITION;
         cfg.min_position = RESET_MIN_POSITION;
         cfg.settle_ticks = RESET_SETTLE_TICKS;
         phase            = PHASE_IDLE;
         settle_left      = 8'd0;
         dir_up           = 1'b0;
         edges_armed      = 1'b1;
         led              = 1'b0;
         pos              = 8'd0;
         position_reports.delete();
         mismatches       = 0;
      end else begin
         // register port: follow writes, check read data
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (paddr[3:2])
                  REG_MAX_POSITION: cfg.max_position = pwdata[7:0];
                  REG_MIN_POSITION: cfg.min_position = pwdata[7:0];
                  REG_SETTLE_TICKS: cfg.settle_ticks = pwdata[7:0];
                  default: ;
               endcase
            end else begin
               reg_known = 1'b1;
               reg_value = 8'd0;
               case (paddr[3:2])
                  REG_MAX_POSITION: reg_value = cfg.max_position;
                  REG_MIN_POSITION: reg_value = cfg.min_position;
                  REG_SETTLE_TICKS: reg_value = cfg.settle_ticks;
                  default: reg_known = 1'b0;
               endcase
               if (reg_known) compare_field("prdata", reg_value, prdata[7:0]);
            end
         end

         // result side: compare against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (position_reports.size() == 0) begin
               $error("result item arrived with nothing expected");
               mismatches++;
            end else begin
               want = position_reports.pop_front();
               compare_field("position", want.position, rsp_position);
               compare_field("display_update", 8'(want.display_update),
                             8'(rsp_display_update));
               compare_field("led_level", 8'(want.led_level), 8'(rsp_led_level));
               compare_field("armed", 8'(want.armed), 8'(rsp_armed));
            end
         end

         // input side: predict the result of each accepted item
         if (req_valid && req_ready) begin
            it.operation    = req_operation;
            it.edge_a       = req_edge_a;
            it.edge_b       = req_edge_b;
            it.level_a      = req_level_a;
            it.level_b      = req_level_b;
            it.new_position = req_new_position;
            decode_item(it, want);
            position_reports.push_back(want);
         end
      end
      outstanding = position_reports.size();
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb
   import rewc_pkg::*;
();

   localparam logic [1:0] REG_UNUSED       = 2'd3;
   localparam int         CYCLE_LIMIT      = 400000;
   localparam int         LONG_HOLD_CYCLES = 300;
   localparam int         PHASE_ITEMS      = 120;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_operation    = 1'b0;
   logic        req_edge_a       = 1'b0;
   logic        req_edge_b       = 1'b0;
   logic        req_level_a      = 1'b0;
   logic        req_level_b      = 1'b0;
   logic [7:0]  req_new_position = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [7:0]  rsp_position;
   logic        rsp_display_update;
   logic        rsp_led_level;
   logic        rsp_armed;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [3:0]  paddr            = 4'd0;
   logic [31:0] pwdata           = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   int mismatches;
   int outstanding;

   // stimulus bookkeeping
   int         sent        = 0;
   int         holds_asked = 0;
   bit         quiet       = 1'b0;
   bit         pauses      = 1'b0;
   logic [7:0] cur_max     = RESET_MAX_POSITION;
   logic [7:0] cur_min     = RESET_MIN_POSITION;
   logic [7:0] cur_settle  = RESET_SETTLE_TICKS;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rotary_encoder_wrap_counter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_edge_a         (req_edge_a),
      .req_edge_b         (req_edge_b),
      .req_level_a        (req_level_a),
      .req_level_b        (req_level_b),
      .req_new_position   (req_new_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_position       (rsp_position),
      .rsp_display_update (rsp_display_update),
      .rsp_led_level      (rsp_led_level),
      .rsp_armed          (rsp_armed),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   rewc_checker watch (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_edge_a         (req_edge_a),
      .req_edge_b         (req_edge_b),
      .req_level_a        (req_level_a),
      .req_level_b        (req_level_b),
      .req_new_position   (req_new_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_position       (rsp_position),
      .rsp_display_update (rsp_display_update),
      .rsp_led_level      (rsp_led_level),
      .rsp_armed          (rsp_armed),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   function automatic logic rb();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic item_type mk(input logic op, input logic ea, input logic eb,
                                   input logic la, input logic lb,
                                   input logic [7:0] np);
      item_type it;
      it.operation    = op;
      it.edge_a       = ea;
      it.edge_b       = eb;
      it.level_a      = la;
      it.level_b      = lb;
      it.new_position = np;
      return it;
   endfunction

   // offer one item and hold it until taken, sometimes pause afterwards
   task automatic put(input item_type it);
      req_valid        <= 1'b1;
      req_operation    <= it.operation;
      req_edge_a       <= it.edge_a;
      req_edge_b       <= it.edge_b;
      req_level_a      <= it.level_a;
      req_level_b      <= it.level_b;
      req_new_position <= it.new_position;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (!quiet && pauses && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // stop offering and wait until every result item is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_reg(input logic [1:0] idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] top_pos, input logic [7:0] bottom_pos,
                             input logic [7:0] settle);
      write_reg(REG_MAX_POSITION, top_pos);
      write_reg(REG_MIN_POSITION, bottom_pos);
      write_reg(REG_SETTLE_TICKS, settle);
      cur_max    = top_pos;
      cur_min    = bottom_pos;
      cur_settle = settle;
      read_reg(REG_MAX_POSITION);
      read_reg(REG_MIN_POSITION);
      read_reg(REG_SETTLE_TICKS);
   endtask

   // a clean detent: load, one edge, channels high, then settle, step, display, re-arm
   task automatic clean_turn(input logic up, input logic [7:0] start);
      put(mk(OP_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, start));
      put(mk(OP_TICK, !up, up, 1'b0, 1'b0, 8'd0));
      put(mk(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0));
      repeat (int'(cur_settle) + 3) put(mk(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
   endtask

   // a well-formed turn with random content and stray edges
   task automatic random_turn();
      int         k;
      logic [7:0] start;
      // sometimes start from a loaded position at or next to the range ends, or at random
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 4))
            0:       start = cur_min;
            1:       start = cur_max;
            2:       start = cur_min - 8'd1;
            3:       start = cur_max + 8'd1;
            default: start = 8'($urandom);
         endcase
         put(mk(OP_LOAD, rb(), rb(), rb(), rb(), start));
      end
      // the edge that sets the direction, either or both channels
      k = $urandom_range(1, 3);
      put(mk(OP_TICK, k[0], k[1], rb(), rb(), 8'($urandom)));
      // channels not yet both high
      repeat ($urandom_range(0, 2))
         put(mk(OP_TICK, rb(), rb(), 1'b0, rb(), 8'($urandom)));
      // settle window, step, display and re-arm; levels mostly high
      repeat (int'(cur_settle) + 4)
         put(mk(OP_TICK, $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                8'($urandom)));
   endtask

   // result side: random stalls, one long hold when asked, none at the end
   initial begin : receiver
      int holds_given;
      holds_given = 0;
      forever begin
         if (holds_asked > holds_given) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            holds_given++;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int target;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part with no settle wait
      set_config(8'd255, 8'd0, 8'd0);
      pauses = 1'b1;
      // loads at both ends, edge flags on a load are ignored
      put(mk(OP_LOAD, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
      put(mk(OP_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
      // both edges at once: channel a wins, direction down
      put(mk(OP_TICK, 1'b1, 1'b1, 1'b0, 1'b0, 8'hFF));
      // edge while disarmed is dropped
      put(mk(OP_TICK, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00));
      // load in the middle of a turn
      put(mk(OP_LOAD, 1'b0, 1'b0, 1'b0, 1'b0, 8'h80));
      put(mk(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
      put(mk(OP_TICK, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
      put(mk(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
      put(mk(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
      put(mk(OP_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
      // wrap below the minimum and above the maximum
      clean_turn(1'b0, 8'h00);
      clean_turn(1'b1, 8'hFF);

      // random part, one register setting per phase
      for (int p = 0; p < 7; p++) begin
         drain();
         case (p)
            0: set_config(8'd255, 8'd0, 8'd3);
            1: begin
               write_reg(REG_UNUSED, 8'hA5);
               set_config(8'd9, 8'd3, 8'd0);
            end
            2: set_config(8'd50, 8'd200, 8'd1);
            3: set_config(8'd0, 8'd0, 8'd2);
            4: set_config(8'd255, 8'd255, 8'd0);
            5: set_config(8'($urandom), 8'($urandom), 8'd255);
            default: begin
               set_config(8'($urandom_range(128, 255)), 8'($urandom_range(0, 127)),
                          8'($urandom_range(0, 6)));
               quiet = 1'b1;
            end
         endcase
         // in the first phase, fill the block up while the result side holds off
         if (p == 0) holds_asked++;
         target = sent + PHASE_ITEMS;
         while (sent < target) begin
            pauses = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 4))
                  put(mk(rb(), rb(), rb(), rb(), rb(), 8'($urandom)));
            else
               random_turn();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
